// ===== rtl/wcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wcp_pkg;

  localparam int SEGMENT_LIMIT = 512;
  localparam int CNT_W = 10;
  localparam int SLOT_W = 9;
  localparam int COL_W = 12;

  localparam logic [31:0] FOCAL_RST = 32'd10485760;
  localparam logic [31:0] HALFW_RST = 32'd10485760;
  localparam logic [11:0] MINX_RST = 12'd0;
  localparam logic [11:0] MAXX_RST = 12'd319;

  localparam logic [1:0] REG_FOCAL = 2'd0;
  localparam logic [1:0] REG_HALFW = 2'd1;
  localparam logic [1:0] REG_MINX = 2'd2;
  localparam logic [1:0] REG_MAXX = 2'd3;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] mag32(input logic [31:0] a);
    mag32 = a[31] ? (32'd0 - a) : a;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wcp_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Registered 32x32 signed multiply, result = floor(a*b / 2^16) low 32 bits.
module wcp_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      p_r
);
  logic signed [63:0] prod;

  assign prod = $signed(a) * $signed(b);

  always_ff @(posedge clk) begin
    p_r <= prod[47:16];
  end
endmodule
`default_nettype wire

// ===== rtl/wcp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared restoring divider: trunc(num*2^16 / den), one quotient bit a cycle.
module wcp_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wcp_pkg::div_req_t     req,
  output wcp_pkg::div_rsp_t     rsp
);
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic [47:0] dvd_r, dvd_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic        done_r, done_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [48:0] trial;
  logic [47:0] qfix;

  assign trial = {rem_r[47:0], dvd_r[47]} - {17'd0, dsr_r};
  assign qfix = neg_r ? (48'd0 - dvd_r) : dvd_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd48;
      neg_nxt  = req.num[31] ^ req.den[31];
      zero_nxt = (req.den == 32'd0);
      dvd_nxt  = req.num[31] ? (48'd0 - {{16{req.num[31]}}, req.num} * 48'd65536)
                             : ({16'd0, req.num} << 16);
      rem_nxt  = '0;
      dsr_nxt  = wcp_pkg::mag32(req.den);
    end else if (busy_r) begin
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        quo_nxt  = zero_r ? wcp_pkg::S32_MAX : qfix[31:0];
      end else begin
        cnt_nxt = cnt_r - 7'd1;
        if (!trial[48]) begin
          rem_nxt = trial;
          dvd_nxt = {dvd_r[46:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[47:0], dvd_r[47]};
          dvd_nxt = {dvd_r[46:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    quo_r  <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule
`default_nettype wire

// ===== rtl/wall_clip_project_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Wall clip and projection.
// Input channel in_valid/in_ready carries one view-space wall (two 16.16
// endpoints and a texel length). Output channel out_valid/out_ready returns
// one result item per wall: visible flag, list-full flag, segment slot,
// pixel span, clipped ends, u start, slope, orientation and u scale.
// The user must write the configuration registers through cfg_we/cfg_idx/
// cfg_data only while the block is idle; the block does not enforce it.
// One item at a time. A wall behind the camera or outside the frustum is
// dropped in the cull step, a back-facing wall after the facing test; a
// visible wall goes through left clip, right clip, projection, slope and u
// scale. The time is set by up to eight 16.16 divisions on the one shared
// bit-serial divider and by the multiplies on the shared multiplier.
// in_ready is low while an item is in work or its result waits, and rises
// the cycle after the result is taken.
// Reset (rst_n low, synchronous) restores the registers to their defaults,
// clears the segment counter and drops any item in work.
// A stalled receiver holds out_valid and the result; no new item is taken.
module wall_clip_project_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_start_x,
  input  wire logic [31:0] in_start_z,
  input  wire logic [31:0] in_end_x,
  input  wire logic [31:0] in_end_z,
  input  wire logic [31:0] in_texel_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_visible,
  output logic             out_list_full,
  output logic [8:0]       out_segment_slot,
  output logic [11:0]      out_pixel_start,
  output logic [11:0]      out_pixel_end,
  output logic [31:0]      out_clipped_z0,
  output logic [31:0]      out_clipped_z1,
  output logic [31:0]      out_u_start,
  output logic [31:0]      out_view_x0,
  output logic [31:0]      out_slope,
  output logic [31:0]      out_u_scale,
  output logic             out_orient,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data
);
  // Sequencer steps
  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_CULL  = 6'd1;
  localparam logic [5:0] S_FA    = 6'd2;  // mul z0*dx
  localparam logic [5:0] S_FC    = 6'd4;
  localparam logic [5:0] S_LA    = 6'd5;  // left clip: x0*z1
  localparam logic [5:0] S_LB    = 6'd6;  // z0*x1
  localparam logic [5:0] S_LD    = 6'd8;  // wait div
  localparam logic [5:0] S_LE    = 6'd9;  // s div
  localparam logic [5:0] S_LF    = 6'd10; // wait s
  localparam logic [5:0] S_LG    = 6'd11; // mul tex_rem*s
  localparam logic [5:0] S_RA    = 6'd13;
  localparam logic [5:0] S_RB    = 6'd14;
  localparam logic [5:0] S_RC    = 6'd15;
  localparam logic [5:0] S_RD    = 6'd16;
  localparam logic [5:0] S_RE    = 6'd17;
  localparam logic [5:0] S_RF    = 6'd18;
  localparam logic [5:0] S_RG    = 6'd19;
  localparam logic [5:0] S_RH    = 6'd20;
  localparam logic [5:0] S_P0A   = 6'd21; // mul x0*f
  localparam logic [5:0] S_P0B   = 6'd22; // div
  localparam logic [5:0] S_P1A   = 6'd24;
  localparam logic [5:0] S_P1B   = 6'd25;
  localparam logic [5:0] S_SPAN  = 6'd27;
  localparam logic [5:0] S_SLA   = 6'd28; // slope div
  localparam logic [5:0] S_USB   = 6'd30;
  localparam logic [5:0] S_OUT   = 6'd31;
  localparam logic [5:0] S_MW    = 6'd32; // mul latency slot

  logic [5:0]  st_r, st_nxt, ret_r, ret_nxt;
  logic [31:0] focal_r, halfw_r;
  logic [11:0] minx_r, maxx_r;
  logic [wcp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [31:0] x0_r, z0_r, x1_r, z1_r, tl_r, tr_r, cu_r;
  logic [31:0] x0_nxt, z0_nxt, x1_nxt, z1_nxt, tl_nxt, tr_nxt, cu_nxt;
  logic [31:0] t_r, t_nxt, xz_r, xz_nxt, p0_r, p0_nxt, p1_r, p1_nxt;
  logic [31:0] sl_r, sl_nxt, den_r, den_nxt;
  logic        or_r, or_nxt;

  logic [31:0] ma, mb, mp, ma_r, mb_r, ma_nxt, mb_nxt;
  wcp_pkg::div_req_t dreq;
  wcp_pkg::div_rsp_t drsp;

  // Result register
  logic        ov_r, ov_nxt;
  logic        rvis_r, rfull_r, rvis_nxt, rfull_nxt, ror_r, ror_nxt;
  logic [8:0]  rslot_r, rslot_nxt;
  logic [11:0] rps_r, rpe_r, rps_nxt, rpe_nxt;
  logic [31:0] rz0_r, rz1_r, ru_r, rx0_r, rsl_r, rus_r;
  logic [31:0] rz0_nxt, rz1_nxt, ru_nxt, rx0_nxt, rsl_nxt, rus_nxt;

  assign ma = ma_r;
  assign mb = mb_r;

  wcp_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(mp));
  wcp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= wcp_pkg::FOCAL_RST;
      halfw_r <= wcp_pkg::HALFW_RST;
      minx_r  <= wcp_pkg::MINX_RST;
      maxx_r  <= wcp_pkg::MAXX_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        wcp_pkg::REG_FOCAL: focal_r <= cfg_data;
        wcp_pkg::REG_HALFW: halfw_r <= cfg_data;
        wcp_pkg::REG_MINX:  minx_r  <= cfg_data[11:0];
        wcp_pkg::REG_MAXX:  maxx_r  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (st_r == S_IDLE) && !ov_r;

  // Combinational helpers
  logic [31:0] dx, dz, nz0, nz1, r0;
  logic        lft0, lft1, rgt0, rgt1, zmaj;
  logic signed [31:0] sp0, sp1;
  logic signed [12:0] smax, smin;
  assign dx   = x1_r - x0_r;
  assign dz   = z1_r - z0_r;
  assign nz0  = 32'd0 - z0_r;
  assign nz1  = 32'd0 - z1_r;
  assign lft0 = $signed(x0_r) < $signed(nz0);
  assign lft1 = $signed(x1_r) < $signed(nz1);
  assign rgt0 = $signed(x0_r) > $signed(z0_r);
  assign rgt1 = $signed(x1_r) > $signed(z1_r);
  assign zmaj = (dz != 32'd0) && (wcp_pkg::mag32(dz) > wcp_pkg::mag32(dx));
  assign r0   = drsp.quo + halfw_r + 32'h8000;
  assign sp0  = $signed(p0_r);
  assign sp1  = $signed(p1_r);
  assign smax = $signed({1'b0, maxx_r});
  assign smin = $signed({1'b0, minx_r});

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; cnt_nxt = cnt_r;
    x0_nxt = x0_r; z0_nxt = z0_r; x1_nxt = x1_r; z1_nxt = z1_r;
    tl_nxt = tl_r; tr_nxt = tr_r; cu_nxt = cu_r;
    t_nxt = t_r; xz_nxt = xz_r; p0_nxt = p0_r; p1_nxt = p1_r;
    sl_nxt = sl_r; den_nxt = den_r; or_nxt = or_r;
    ma_nxt = ma_r; mb_nxt = mb_r;
    dreq = '0;
    ov_nxt = ov_r; rvis_nxt = rvis_r; rfull_nxt = rfull_r; ror_nxt = ror_r;
    rslot_nxt = rslot_r; rps_nxt = rps_r; rpe_nxt = rpe_r;
    rz0_nxt = rz0_r; rz1_nxt = rz1_r; ru_nxt = ru_r; rx0_nxt = rx0_r;
    rsl_nxt = rsl_r; rus_nxt = rus_r;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          x0_nxt = in_start_x; z0_nxt = in_start_z;
          x1_nxt = in_end_x;   z1_nxt = in_end_z;
          tl_nxt = in_texel_length; tr_nxt = in_texel_length;
          cu_nxt = '0;
          st_nxt = S_CULL;
        end
      end
      S_CULL: begin
        // Culled results default to all-zero
        rvis_nxt = 1'b0; rfull_nxt = 1'b0; ror_nxt = 1'b0; rslot_nxt = '0;
        rps_nxt = '0; rpe_nxt = '0; rz0_nxt = '0; rz1_nxt = '0; ru_nxt = '0;
        rx0_nxt = '0; rsl_nxt = '0; rus_nxt = '0;
        if ((z0_r[31] && z1_r[31]) || (lft0 && lft1) || (rgt0 && rgt1)) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          ma_nxt = z0_r; mb_nxt = dx; st_nxt = S_MW; ret_nxt = S_FA;
        end
      end
      S_MW: st_nxt = ret_r;
      S_FA: begin
        t_nxt = mp; ma_nxt = x0_r; mb_nxt = dz; st_nxt = S_MW; ret_nxt = S_FC;
      end
      S_FC: begin
        if ((t_r - mp) >= 32'h8000_0000) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else if (lft0) begin
          ma_nxt = x0_r; mb_nxt = z1_r; st_nxt = S_MW; ret_nxt = S_LA;
        end else begin
          st_nxt = S_RA;
        end
      end
      // Left clip
      S_LA: begin
        t_nxt = mp; ma_nxt = z0_r; mb_nxt = x1_r; st_nxt = S_MW; ret_nxt = S_LB;
      end
      S_LB: begin
        xz_nxt = t_r - mp;
        if ((32'd0 - dz - dx) != 32'd0) begin
          dreq.start = 1'b1; dreq.num = t_r - mp; dreq.den = 32'd0 - dz - dx;
          st_nxt = S_LD;
        end else st_nxt = S_LE;
      end
      S_LD: if (drsp.done) begin xz_nxt = drsp.quo; st_nxt = S_LE; end
      S_LE: begin
        if (zmaj) begin
          dreq.start = 1'b1; dreq.num = xz_r - z0_r; dreq.den = dz; st_nxt = S_LF;
        end else if (dx != 32'd0) begin
          dreq.start = 1'b1; dreq.num = 32'd0 - xz_r - x0_r; dreq.den = dx; st_nxt = S_LF;
        end else begin
          x0_nxt = 32'd0 - xz_r; z0_nxt = xz_r; st_nxt = S_RA;
        end
      end
      S_LF: if (drsp.done) begin
        x0_nxt = 32'd0 - xz_r; z0_nxt = xz_r;
        if (drsp.quo != 32'd0) begin
          ma_nxt = tr_r; mb_nxt = drsp.quo; st_nxt = S_MW; ret_nxt = S_LG;
        end else st_nxt = S_RA;
      end
      S_LG: begin
        cu_nxt = cu_r + mp; tr_nxt = tl_r - (cu_r + mp); st_nxt = S_RA;
      end
      // Right clip
      S_RA: begin
        if (rgt1) begin
          ma_nxt = x0_r; mb_nxt = z1_r; st_nxt = S_MW; ret_nxt = S_RB;
        end else begin
          ma_nxt = x0_r; mb_nxt = focal_r; st_nxt = S_MW; ret_nxt = S_P0A;
        end
      end
      S_RB: begin
        t_nxt = mp; ma_nxt = z0_r; mb_nxt = x1_r; st_nxt = S_MW; ret_nxt = S_RC;
      end
      S_RC: begin
        xz_nxt = t_r - mp;
        if ((dz - dx) != 32'd0) begin
          dreq.start = 1'b1; dreq.num = t_r - mp; dreq.den = dz - dx; st_nxt = S_RD;
        end else st_nxt = S_RE;
      end
      S_RD: if (drsp.done) begin xz_nxt = drsp.quo; st_nxt = S_RE; end
      S_RE: begin
        if (zmaj) begin
          dreq.start = 1'b1; dreq.num = xz_r - z1_r; dreq.den = dz; st_nxt = S_RF;
        end else if (dx != 32'd0) begin
          dreq.start = 1'b1; dreq.num = xz_r - x1_r; dreq.den = dx; st_nxt = S_RF;
        end else begin
          x1_nxt = xz_r; z1_nxt = xz_r; st_nxt = S_RH;
        end
      end
      S_RF: if (drsp.done) begin
        x1_nxt = xz_r; z1_nxt = xz_r;
        if (drsp.quo != 32'd0) begin
          ma_nxt = tr_r; mb_nxt = drsp.quo; st_nxt = S_MW; ret_nxt = S_RG;
        end else st_nxt = S_RH;
      end
      S_RG: begin
        tl_nxt = tl_r + mp; tr_nxt = tl_r + mp - cu_r; st_nxt = S_RH;
      end
      S_RH: begin
        ma_nxt = x0_r; mb_nxt = focal_r; st_nxt = S_MW; ret_nxt = S_P0A;
      end
      // Projection
      S_P0A: begin
        dreq.start = 1'b1; dreq.num = mp; dreq.den = z0_r; st_nxt = S_P0B;
      end
      S_P0B: if (drsp.done) begin
        p0_nxt = {{16{r0[31]}}, r0[31:16]};
        ma_nxt = x1_r; mb_nxt = focal_r; st_nxt = S_MW; ret_nxt = S_P1A;
      end
      S_P1A: begin
        dreq.start = 1'b1; dreq.num = mp; dreq.den = z1_r; st_nxt = S_P1B;
      end
      S_P1B: if (drsp.done) begin
        p1_nxt = {{16{r0[31]}}, r0[31:16]} - 32'd1; st_nxt = S_SPAN;
      end
      S_SPAN: begin
        if (sp0 > sp1 || sp0 > smax || sp1 < smin) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else if (cnt_r >= wcp_pkg::CNT_W'(wcp_pkg::SEGMENT_LIMIT)) begin
          rfull_nxt = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          rslot_nxt = cnt_r[wcp_pkg::SLOT_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
          if (sp0 < 0) p0_nxt = '0;
          if (sp1 > smax) p1_nxt = {20'd0, maxx_r};
          dreq.start = 1'b1;
          if (wcp_pkg::mag32(dx) > wcp_pkg::mag32(dz)) begin
            dreq.num = dz; dreq.den = dx; den_nxt = dx; or_nxt = 1'b0;
          end else begin
            dreq.num = dx; dreq.den = dz; den_nxt = dz; or_nxt = 1'b1;
          end
          st_nxt = S_SLA;
        end
      end
      S_SLA: if (drsp.done) begin
        sl_nxt = drsp.quo;
        dreq.start = 1'b1; dreq.num = tr_r; dreq.den = den_r; st_nxt = S_USB;
      end
      S_USB: if (drsp.done) begin
        rvis_nxt = 1'b1; ror_nxt = or_r;
        rps_nxt = p0_r[11:0]; rpe_nxt = p1_r[11:0];
        rz0_nxt = z0_r; rz1_nxt = z1_r; ru_nxt = cu_r; rx0_nxt = x0_r;
        rsl_nxt = (p0_r == p1_r) ? 32'd0 : sl_r;
        rus_nxt = drsp.quo;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ret_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    x0_r <= x0_nxt; z0_r <= z0_nxt; x1_r <= x1_nxt; z1_r <= z1_nxt;
    tl_r <= tl_nxt; tr_r <= tr_nxt; cu_r <= cu_nxt; t_r <= t_nxt; xz_r <= xz_nxt;
    p0_r <= p0_nxt; p1_r <= p1_nxt; sl_r <= sl_nxt; den_r <= den_nxt; or_r <= or_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt;
    rvis_r <= rvis_nxt; rfull_r <= rfull_nxt; ror_r <= ror_nxt; rslot_r <= rslot_nxt;
    rps_r <= rps_nxt; rpe_r <= rpe_nxt; rz0_r <= rz0_nxt; rz1_r <= rz1_nxt;
    ru_r <= ru_nxt; rx0_r <= rx0_nxt; rsl_r <= rsl_nxt; rus_r <= rus_nxt;
  end

  assign out_valid = ov_r;
  assign out_visible = rvis_r;
  assign out_list_full = rfull_r;
  assign out_segment_slot = rslot_r;
  assign out_pixel_start = rps_r;
  assign out_pixel_end = rpe_r;
  assign out_clipped_z0 = rz0_r;
  assign out_clipped_z1 = rz1_r;
  assign out_u_start = ru_r;
  assign out_view_x0 = rx0_r;
  assign out_slope = rsl_r;
  assign out_u_scale = rus_r;
  assign out_orient = ror_r;
endmodule
`default_nettype wire

// ===== rtl/wcp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the wall clip block.
module wcp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_visible,
  input wire logic        out_list_full,
  input wire logic [31:0] out_slope
);
  // One item in flight: no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready with result pending");

  // Result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible))
    else $error("result dropped during stall");

  // Visible and list full are exclusive
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_visible && out_list_full)) else $error("bad flags");

  // Hidden results carry zero slope
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_slope == 32'd0) else $error("culled slope");

  // Accepting an item drops ready
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind wall_clip_project_top wcp_checker u_wcp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_visible(out_visible),
  .out_list_full(out_list_full), .out_slope(out_slope)
);
`default_nettype wire

// ===== tb/sv/wall_clip_checker.sv =====
`timescale 1ns / 1ps
module wall_clip_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_z,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_z,
  input  logic [31:0] in_texel_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_visible,
  input  logic        out_list_full,
  input  logic [8:0]  out_segment_slot,
  input  logic [11:0] out_pixel_start,
  input  logic [11:0] out_pixel_end,
  input  logic [31:0] out_clipped_z0,
  input  logic [31:0] out_clipped_z1,
  input  logic [31:0] out_u_start,
  input  logic [31:0] out_view_x0,
  input  logic [31:0] out_slope,
  input  logic [31:0] out_u_scale,
  input  logic        out_orient,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic        visible;
    logic        list_full;
    logic [8:0]  slot;
    logic [11:0] pstart;
    logic [11:0] pend;
    logic [31:0] z0;
    logic [31:0] z1;
    logic [31:0] ustart;
    logic [31:0] x0;
    logic [31:0] slope;
    logic [31:0] uscale;
    logic        orient;
  } seg_t;

  seg_t segq[$];
  logic signed [31:0] focal, halfw;
  logic [11:0] minx, maxx;
  logic [9:0] seg_cnt;

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[47:16];
  endfunction

  function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] q;
    if (b == 0) return wcp_pkg::S32_MAX;
    q = (64'(a) <<< 16) / 64'(b);
    return q[31:0];
  endfunction

  function automatic logic signed [31:0] fx_round(logic signed [31:0] a);
    logic signed [31:0] t;
    t = a + 32'sh8000;
    return t >>> 16;
  endfunction

  function automatic logic [31:0] absu(logic signed [31:0] a);
    return a[31] ? 32'd0 - a : a;
  endfunction

  // project one wall; updates the segment counter
  function automatic seg_t project_wall(logic signed [31:0] x0, logic signed [31:0] z0,
                                        logic signed [31:0] x1, logic signed [31:0] z1,
                                        logic signed [31:0] tlen);
    seg_t r;
    logic signed [31:0] trem, cu, dx, dz, xz, s, p0, p1, sl, den, d, adj;
    logic ori;
    r = '0;
    trem = tlen;
    cu = 0;
    if (z0 < 0 && z1 < 0) return r;
    if ((x0 < -z0 && x1 < -z1) || (x0 > z0 && x1 > z1)) return r;
    dx = x1 - x0;
    dz = z1 - z0;
    if ($signed(fx_mul(z0, dx) - fx_mul(x0, dz)) < 0) return r;
    // left frustum line
    if (x0 < -z0) begin
      d = -dz - dx;
      xz = fx_mul(x0, z1) - fx_mul(z0, x1);
      if (d != 0) xz = fx_div(xz, d);
      s = 0;
      if (dz != 0 && absu(dz) > absu(dx)) s = fx_div(xz - z0, dz);
      else if (dx != 0) s = fx_div(-xz - x0, dx);
      x0 = -xz;
      z0 = xz;
      if (s != 0) begin
        cu = cu + fx_mul(trem, s);
        trem = tlen - cu;
      end
      dx = x1 - x0;
      dz = z1 - z0;
    end
    // right frustum line
    if (x1 > z1) begin
      d = dz - dx;
      xz = fx_mul(x0, z1) - fx_mul(z0, x1);
      if (d != 0) xz = fx_div(xz, d);
      s = 0;
      if (dz != 0 && absu(dz) > absu(dx)) s = fx_div(xz - z1, dz);
      else if (dx != 0) s = fx_div(xz - x1, dx);
      x1 = xz;
      z1 = xz;
      if (s != 0) begin
        adj = tlen + fx_mul(trem, s);
        trem = adj - cu;
        tlen = adj;
      end
      dx = x1 - x0;
      dz = z1 - z0;
    end
    p0 = fx_round(fx_div(fx_mul(x0, focal), z0) + halfw);
    p1 = fx_round(fx_div(fx_mul(x1, focal), z1) + halfw) - 1;
    if (p0 > p1) return r;
    if (p0 > $signed({20'd0, maxx}) || p1 < $signed({20'd0, minx})) return r;
    if (seg_cnt >= wcp_pkg::SEGMENT_LIMIT) begin
      r.list_full = 1'b1;
      return r;
    end
    r.slot = seg_cnt[8:0];
    seg_cnt = seg_cnt + 1'b1;
    if (p0 < 0) p0 = 0;
    if (p1 > $signed({20'd0, maxx})) p1 = {20'd0, maxx};
    if (absu(dx) > absu(dz)) begin
      sl = fx_div(dz, dx);
      den = dx;
      ori = 1'b0;
    end else begin
      sl = fx_div(dx, dz);
      den = dz;
      ori = 1'b1;
    end
    if (p0 == p1) sl = 0;
    r.visible = 1'b1;
    r.pstart = p0[11:0];
    r.pend = p1[11:0];
    r.z0 = z0;
    r.z1 = z1;
    r.ustart = cu;
    r.x0 = x0;
    r.slope = sl;
    r.uscale = fx_div(trem, den);
    r.orient = ori;
    return r;
  endfunction

  always @(posedge clk) begin
    seg_t got, want;
    if (!rst_n) begin
      focal <= wcp_pkg::FOCAL_RST;
      halfw <= wcp_pkg::HALFW_RST;
      minx <= wcp_pkg::MINX_RST;
      maxx <= wcp_pkg::MAXX_RST;
      seg_cnt = '0;
      segq.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          wcp_pkg::REG_FOCAL: focal <= cfg_data;
          wcp_pkg::REG_HALFW: halfw <= cfg_data;
          wcp_pkg::REG_MINX: minx <= cfg_data[11:0];
          wcp_pkg::REG_MAXX: maxx <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        segq.push_back(project_wall(in_start_x, in_start_z, in_end_x, in_end_z,
                                    in_texel_length));
      // compare each result with the oldest prediction
      if (out_valid && out_ready) begin
        got = '{out_visible, out_list_full, out_segment_slot, out_pixel_start,
                out_pixel_end, out_clipped_z0, out_clipped_z1, out_u_start,
                out_view_x0, out_slope, out_u_scale, out_orient};
        if (segq.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = segq.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("result mismatch\n  exp %p\n  got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= segq.size();
    end
  end
endmodule

// ===== tb/sv/wall_clip_project_top_test.sv =====
`timescale 1ns / 1ps
module wall_clip_project_top_test;
  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [31:0] in_start_x, in_start_z, in_end_x, in_end_z, in_texel_length;
  logic out_visible, out_list_full, out_orient;
  logic [8:0] out_segment_slot;
  logic [11:0] out_pixel_start, out_pixel_end;
  logic [31:0] out_clipped_z0, out_clipped_z1, out_u_start, out_view_x0;
  logic [31:0] out_slope, out_u_scale;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_data;
  int fail_count, pending;
  int cycles;
  bit hold_off;

  wall_clip_project_top uut (.*);
  wall_clip_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  initial begin
    int k;
    out_ready = 0;
    k = 0;
    forever begin
      @(negedge clk);
      k++;
      if (hold_off) out_ready <= 0;
      else if ((k / 64) % 3 == 0) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [31:0] rnd_fx();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return $signed($urandom_range(0, 400 << 16)) - (200 << 16);
    endcase
  endfunction

  task automatic send_wall(logic [31:0] x0, logic [31:0] z0, logic [31:0] x1,
                           logic [31:0] z1, logic [31:0] tl);
    @(negedge clk);
    in_valid <= 1;
    in_start_x <= x0;
    in_start_z <= z0;
    in_end_x <= x1;
    in_end_z <= z1;
    in_texel_length <= tl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 0;
  endtask

  // mostly front-facing walls in front of the camera, some noise
  task automatic send_random();
    logic [31:0] z0, z1, x0, x1;
    if ($urandom_range(0, 4) == 0) begin
      send_wall(rnd_fx(), rnd_fx(), rnd_fx(), rnd_fx(), rnd_fx());
    end else begin
      z0 = $urandom_range(1 << 16, 300 << 16);
      z1 = $urandom_range(1 << 16, 300 << 16);
      x0 = $signed($urandom_range(0, 2 * z0)) - $signed(z0 + $urandom_range(0, 40 << 16));
      x1 = $signed($urandom_range(0, z1)) + $signed($urandom_range(0, 40 << 16));
      send_wall(x0, z0, x1, z1, $urandom_range(0, 512 << 16));
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic burst(int n);
    int m;
    while (n > 0) begin
      m = $urandom_range(1, 12);
      repeat (m) if (n > 0) begin
        send_random();
        n--;
      end
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  initial begin
    hold_off = 0;
    rst_n = 0;
    in_valid = 0;
    in_start_x = 0;
    in_start_z = 0;
    in_end_x = 0;
    in_end_z = 0;
    in_texel_length = 0;
    cfg_we = 0;
    cfg_idx = wcp_pkg::REG_FOCAL;
    cfg_data = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: behind camera, outside frustum, back-facing, clipped, zero divisors
    send_wall(0, 32'hFFFF_0000, 0, 32'hFFFE_0000, 1 << 16);
    send_wall(-(50 << 16), 10 << 16, -(60 << 16), 20 << 16, 1 << 16);
    send_wall(50 << 16, 10 << 16, 60 << 16, 20 << 16, 1 << 16);
    send_wall(5 << 16, 20 << 16, -(5 << 16), 20 << 16, 1 << 16);
    send_wall(-(5 << 16), 20 << 16, 5 << 16, 20 << 16, 64 << 16);
    send_wall(-(40 << 16), 20 << 16, 40 << 16, 20 << 16, 64 << 16);
    send_wall(-(40 << 16), 10 << 16, 5 << 16, 30 << 16, 32'h8000_0000);
    send_wall(-(5 << 16), 30 << 16, 40 << 16, 10 << 16, 32'h7FFF_FFFF);
    send_wall(0, 0, 0, 0, 0);
    send_wall(-(1 << 16), 1 << 16, 1 << 16, 1 << 16, 1 << 16);
    send_wall(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_wall(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_wall(-(10 << 16), 10 << 16, 10 << 16, 10 << 16, 1 << 16);
    send_wall(0, 10 << 16, 0, 40 << 16, 1 << 16);
    drain();

    // pressure: receiver holds off while items keep coming
    fork
      begin
        hold_off = 1;
        repeat (2000) @(negedge clk);
        hold_off = 0;
      end
      burst(6);
    join
    burst(300);
    drain();

    // extreme register settings
    write_reg(wcp_pkg::REG_FOCAL, 32'h7FFF_FFFF);
    write_reg(wcp_pkg::REG_HALFW, 32'h8000_0000);
    write_reg(wcp_pkg::REG_MINX, 32'h0000_0FFF);
    write_reg(wcp_pkg::REG_MAXX, 32'h0000_0000);
    burst(80);
    drain();
    write_reg(wcp_pkg::REG_FOCAL, 32'h8000_0000);
    write_reg(wcp_pkg::REG_HALFW, 32'h7FFF_FFFF);
    write_reg(wcp_pkg::REG_MINX, 32'h0000_0000);
    write_reg(wcp_pkg::REG_MAXX, 32'h0000_0FFF);
    burst(80);
    drain();
    write_reg(wcp_pkg::REG_FOCAL, 32'hFFFF_FFFF);
    write_reg(wcp_pkg::REG_HALFW, 32'h0000_0000);
    burst(60);
    drain();
    // wide screen so the segment list fills up
    write_reg(wcp_pkg::REG_FOCAL, 100 << 16);
    write_reg(wcp_pkg::REG_HALFW, 2000 << 16);
    write_reg(wcp_pkg::REG_MINX, 32'h0000_0000);
    write_reg(wcp_pkg::REG_MAXX, 32'h0000_0FFF);
    burst(450);
    drain();
    write_reg(wcp_pkg::REG_FOCAL, 160 << 16);
    write_reg(wcp_pkg::REG_HALFW, 160 << 16);
    write_reg(wcp_pkg::REG_MINX, 32'h0000_0010);
    write_reg(wcp_pkg::REG_MAXX, 32'h0000_013F);
    burst(300);
    drain();

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/wcp_pkg.sv
rtl/wcp_mul.sv
rtl/wcp_div.sv
rtl/wall_clip_project_top.sv
rtl/wcp_checker.sv
tb/sv/wall_clip_checker.sv
tb/sv/wall_clip_project_top_test.sv
